// File: rtl/master_poll_controller_top_assert.svh
// assertion macros for the poll controller
`ifndef MASTER_POLL_CONTROLLER_TOP_ASSERT_SVH
`define MASTER_POLL_CONTROLLER_TOP_ASSERT_SVH

// consequent must hold in the same cycle
`define MPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the next cycle
`define MPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/mpc_pkg.sv
`timescale 1ns / 1ps

package mpc_pkg;

  localparam logic [7:0]  CH_START      = 8'h3E;
  localparam logic [7:0]  CH_SEP        = 8'h3B;
  localparam logic [7:0]  CH_END        = 8'h3C;
  localparam logic [7:0]  LAST_ID_RST   = 8'd5;
  localparam logic [3:0]  RETRY_RST     = 4'd3;
  localparam logic [15:0] NOFRAME_RST   = 16'd10000;
  localparam int          POLL_LEN      = 5;
  localparam int          QDEPTH        = 4;
  localparam int          QAW           = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_RX   = 2'd1,
    KIND_POLL = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IGNORED = 2'd0,
    ST_OK      = 2'd1,
    ST_BADCHK  = 2'd2,
    ST_INCOMPL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_LAST_ID = 2'd0,
    CFG_RETRY   = 2'd1,
    CFG_NOFRAME = 2'd2
  } cfg_idx_e;

  typedef enum logic [7:0] {
    PS_START   = 8'b0000_0001,
    PS_ID      = 8'b0000_0010,
    PS_SEP1    = 8'b0000_0100,
    PS_DATA    = 8'b0000_1000,
    PS_SEP2    = 8'b0001_0000,
    PS_CHK     = 8'b0010_0000,
    PS_END_OK  = 8'b0100_0000,
    PS_END_BAD = 8'b1000_0000
  } parse_e;

  typedef struct packed {
    logic       poll;
    status_e    status;
    logic [7:0] rid;
    logic [7:0] rdat;
    logic [7:0] tgt;
  } cmd_t;

endpackage

// File: rtl/master_poll_controller_top.sv
`timescale 1ns / 1ps

// poll controller: one input item is accepted per cycle while the four-entry command
// queue has room. a transmit slot in the transmit phase gives five results (the poll
// frame, one byte per cycle while out_ready_i is high), every other item gives one
// result. results leave the output register at one per cycle while out_ready_i is high,
// so receive items sustain one item per cycle; poll frames are paced by the serialiser.
// configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.

`include "master_poll_controller_top_assert.svh"

module master_poll_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic        driver_enable_o,
  output logic [1:0]  frame_status_o,
  output logic [7:0]  reply_id_o,
  output logic [7:0]  reply_data_o,
  output logic [7:0]  target_id_o
);

  mpc_pkg::cmd_t cmd, q_data;
  logic          q_full, q_empty, q_pop, in_fire;

  assign in_ready_o = !q_full;
  assign in_fire    = in_valid_i && in_ready_o;

  mpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_fire_i  (in_fire),
    .kind_i     (kind_i),
    .rx_byte_i  (rx_byte_i),
    .cmd_o      (cmd)
  );

  mpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_data)
  );

  mpc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tx_valid_o      (tx_valid_o),
    .tx_byte_o       (tx_byte_o),
    .last_o          (last_o),
    .driver_enable_o (driver_enable_o),
    .frame_status_o  (frame_status_o),
    .reply_id_o      (reply_id_o),
    .reply_data_o    (reply_data_o),
    .target_id_o     (target_id_o)
  );

  `MPC_ASSERT_IMPL(a_poll_end_byte, out_valid_o && tx_valid_o && last_o, tx_byte_o == mpc_pkg::CH_END)
  `MPC_ASSERT_NEXT(a_frame_same_target, out_valid_o && out_ready_i && !last_o, out_valid_o && tx_valid_o && $stable(target_id_o))
  `MPC_ASSERT_IMPL(a_poll_no_status, out_valid_o && tx_valid_o, frame_status_o == mpc_pkg::ST_IGNORED && driver_enable_o)

endmodule

// File: rtl/mpc_front.sv
`timescale 1ns / 1ps

module mpc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_fire_i,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          rx_byte_i,
  output mpc_pkg::cmd_t       cmd_o
);

  logic [7:0]      last_id_q;
  logic [3:0]      retry_lim_q;
  logic [15:0]     nofr_lim_q;
  logic            waiting_q, waiting_d;
  logic [7:0]      slave_q, slave_d;
  logic [3:0]      retry_q, retry_d;
  logic [15:0]     nofr_q, nofr_d;
  mpc_pkg::parse_e step_q, step_d;
  logic [7:0]      held_id_q, held_id_d;
  logic [7:0]      held_data_q, held_data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_id_q   <= mpc_pkg::LAST_ID_RST;
      retry_lim_q <= mpc_pkg::RETRY_RST;
      nofr_lim_q  <= mpc_pkg::NOFRAME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpc_pkg::CFG_LAST_ID: last_id_q   <= cfg_data_i[7:0];
        mpc_pkg::CFG_RETRY:   retry_lim_q <= cfg_data_i[3:0];
        mpc_pkg::CFG_NOFRAME: nofr_lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]       adv;
    logic [4:0]       r;
    logic [16:0]      n;
    mpc_pkg::status_e st;
    waiting_d   = waiting_q;
    slave_d     = slave_q;
    retry_d     = retry_q;
    nofr_d      = nofr_q;
    step_d      = step_q;
    held_id_d   = held_id_q;
    held_data_d = held_data_q;
    adv         = (slave_q >= last_id_q) ? 8'd0 : slave_q + 8'd1;
    r           = {1'b0, retry_q} + 5'd1;
    n           = {1'b0, nofr_q} + 17'd1;
    st          = mpc_pkg::ST_INCOMPL;
    cmd_o       = '{poll: 1'b0, status: mpc_pkg::ST_IGNORED, rid: 8'd0, rdat: 8'd0,
                    tgt: slave_q};
    if (!waiting_q) begin
      if (kind_i == mpc_pkg::KIND_TX) begin
        cmd_o.poll = 1'b1;
        waiting_d  = 1'b1;
      end
    end else if (kind_i == mpc_pkg::KIND_RX || kind_i == mpc_pkg::KIND_POLL) begin
      if (kind_i == mpc_pkg::KIND_RX) begin
        step_d = mpc_pkg::PS_START;
        case (step_q)
          mpc_pkg::PS_START: if (rx_byte_i == mpc_pkg::CH_START) step_d = mpc_pkg::PS_ID;
          mpc_pkg::PS_ID: begin
            held_id_d = rx_byte_i;
            step_d    = mpc_pkg::PS_SEP1;
          end
          mpc_pkg::PS_SEP1: if (rx_byte_i == mpc_pkg::CH_SEP) step_d = mpc_pkg::PS_DATA;
          mpc_pkg::PS_DATA: begin
            held_data_d = rx_byte_i;
            step_d      = mpc_pkg::PS_SEP2;
          end
          mpc_pkg::PS_SEP2: if (rx_byte_i == mpc_pkg::CH_SEP) step_d = mpc_pkg::PS_CHK;
          mpc_pkg::PS_CHK: begin
            step_d = ((held_id_q ^ held_data_q ^ rx_byte_i) == 8'd0) ?
                     mpc_pkg::PS_END_OK : mpc_pkg::PS_END_BAD;
          end
          mpc_pkg::PS_END_OK: if (rx_byte_i == mpc_pkg::CH_END) st = mpc_pkg::ST_OK;
          mpc_pkg::PS_END_BAD: if (rx_byte_i == mpc_pkg::CH_END) st = mpc_pkg::ST_BADCHK;
          default: ;
        endcase
      end
      cmd_o.status = st;
      if (st == mpc_pkg::ST_OK) begin
        cmd_o.rid  = held_id_q;
        cmd_o.rdat = held_data_q;
        slave_d    = adv;
        waiting_d  = 1'b0;
      end else if (st == mpc_pkg::ST_BADCHK) begin
        cmd_o.rid  = held_id_q;
        cmd_o.rdat = held_data_q;
        waiting_d  = 1'b0;
        if (r >= {1'b0, retry_lim_q}) begin
          retry_d = 4'd0;
          slave_d = adv;
        end else begin
          retry_d = r[3:0];
        end
      end else begin
        if (n >= {1'b0, nofr_lim_q}) begin
          nofr_d    = 16'd0;
          slave_d   = adv;
          waiting_d = 1'b0;
        end else begin
          nofr_d = n[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q   <= 1'b0;
      slave_q     <= 8'd0;
      retry_q     <= 4'd0;
      nofr_q      <= 16'd0;
      step_q      <= mpc_pkg::PS_START;
      held_id_q   <= 8'd0;
      held_data_q <= 8'd0;
    end else if (in_fire_i) begin
      waiting_q   <= waiting_d;
      slave_q     <= slave_d;
      retry_q     <= retry_d;
      nofr_q      <= nofr_d;
      step_q      <= step_d;
      held_id_q   <= held_id_d;
      held_data_q <= held_data_d;
    end
  end

endmodule

// File: rtl/mpc_queue.sv
`timescale 1ns / 1ps

module mpc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mpc_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mpc_pkg::cmd_t pop_data_o
);

  mpc_pkg::cmd_t          mem_q [mpc_pkg::QDEPTH];
  logic [mpc_pkg::QAW-1:0] wr_q, rd_q;
  logic [mpc_pkg::QAW:0]   cnt_q;
  logic                    do_push, do_pop;

  assign full_o     = (cnt_q == (mpc_pkg::QAW+1)'(mpc_pkg::QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/mpc_back.sv
`timescale 1ns / 1ps

module mpc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  mpc_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          tx_valid_o,
  output logic [7:0]    tx_byte_o,
  output logic          last_o,
  output logic          driver_enable_o,
  output logic [1:0]    frame_status_o,
  output logic [7:0]    reply_id_o,
  output logic [7:0]    reply_data_o,
  output logic [7:0]    target_id_o
);

  localparam logic [2:0] LAST_STEP = 3'(mpc_pkg::POLL_LEN - 1);

  mpc_pkg::cmd_t cur_q;
  logic          valid_q;
  logic [2:0]    step_q;
  logic          done;

  assign last_o      = !cur_q.poll || (step_q == LAST_STEP);
  assign done        = out_valid_o && out_ready_i && last_o;
  assign q_pop_o     = (!valid_q || done) && !q_empty_i;
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= 3'd0;
    end else if (!valid_q || done) begin
      valid_q <= !q_empty_i;
      step_q  <= 3'd0;
    end else if (out_ready_i) begin
      step_q <= step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  always_comb begin
    tx_byte_o = 8'd0;
    if (cur_q.poll) begin
      case (step_q)
        3'd0:    tx_byte_o = mpc_pkg::CH_START;
        3'd1:    tx_byte_o = cur_q.tgt;
        3'd2:    tx_byte_o = mpc_pkg::CH_SEP;
        3'd3:    tx_byte_o = cur_q.tgt;
        default: tx_byte_o = mpc_pkg::CH_END;
      endcase
    end
  end

  assign tx_valid_o      = cur_q.poll;
  assign driver_enable_o = cur_q.poll;
  assign frame_status_o  = cur_q.status;
  assign reply_id_o      = cur_q.rid;
  assign reply_data_o    = cur_q.rdat;
  assign target_id_o     = cur_q.tgt;

endmodule

// File: tb/sv/master_poll_controller_top_tb.sv
`timescale 1ns / 1ps

module master_poll_controller_top_tb;
  import mpc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_CYCLES = 150;
  localparam int SETTLE       = 10;
  localparam int PHASE_ITEMS  = 90;

  typedef enum logic [2:0] {
    RX_START, RX_ID, RX_SEP1, RX_DATA, RX_SEP2, RX_CHK, RX_END_OK, RX_END_BAD
  } rx_pos_e;

  typedef struct {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       driver_enable;
    status_e    status;
    logic [7:0] reply_id;
    logic [7:0] reply_data;
    logic [7:0] target_id;
  } poll_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        tx_valid_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic        driver_enable_o;
  logic [1:0]  frame_status_o;
  logic [7:0]  reply_id_o;
  logic [7:0]  reply_data_o;
  logic [7:0]  target_id_o;

  master_poll_controller_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tx_valid_o      (tx_valid_o),
    .tx_byte_o       (tx_byte_o),
    .last_o          (last_o),
    .driver_enable_o (driver_enable_o),
    .frame_status_o  (frame_status_o),
    .reply_id_o      (reply_id_o),
    .reply_data_o    (reply_data_o),
    .target_id_o     (target_id_o)
  );

  // own copy of the controller state
  logic        awaiting_reply = 1'b0;
  logic [7:0]  polled_slave   = 8'd0;
  logic [3:0]  retry_tally    = 4'd0;
  logic [15:0] silent_tally   = 16'd0;
  rx_pos_e     parse_pos      = RX_START;
  logic [7:0]  frame_id       = 8'd0;
  logic [7:0]  frame_data     = 8'd0;
  logic [7:0]  top_slave_id   = LAST_ID_RST;
  logic [3:0]  retry_max      = RETRY_RST;
  logic [15:0] silent_max     = NOFRAME_RST;

  poll_result_t poll_results_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit stall_req;
  int stall_left;
  int cycles;
  int mismatches;
  int items_sent;
  int items_used;
  int results_seen;

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               poll_results_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random idling plus a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_req) begin
      stall_left = STALL_CYCLES;
      stall_req  = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on result %0d, %s: got %0h, want %0h", results_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin
    poll_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (poll_results_q.size() == 0) begin
        report_mismatch("item with nothing pending", frame_status_o, 0);
      end else begin
        e = poll_results_q.pop_front();
        if (tx_valid_o !== e.tx_valid) report_mismatch("tx_valid", tx_valid_o, e.tx_valid);
        if (tx_byte_o !== e.tx_byte) report_mismatch("tx_byte", tx_byte_o, e.tx_byte);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
        if (driver_enable_o !== e.driver_enable)
          report_mismatch("driver_enable", driver_enable_o, e.driver_enable);
        if (frame_status_o !== e.status) report_mismatch("frame_status", frame_status_o, e.status);
        if (reply_id_o !== e.reply_id) report_mismatch("reply_id", reply_id_o, e.reply_id);
        if (reply_data_o !== e.reply_data)
          report_mismatch("reply_data", reply_data_o, e.reply_data);
        if (target_id_o !== e.target_id) report_mismatch("target_id", target_id_o, e.target_id);
      end
      results_seen++;
    end
  end

  function automatic void push_result(logic tv, logic [7:0] tb, logic lst, logic de,
                                      status_e st, logic [7:0] rid, logic [7:0] rdat,
                                      logic [7:0] tgt);
    poll_result_t r;
    r.tx_valid      = tv;
    r.tx_byte       = tb;
    r.last          = lst;
    r.driver_enable = de;
    r.status        = st;
    r.reply_id      = rid;
    r.reply_data    = rdat;
    r.target_id     = tgt;
    poll_results_q.push_back(r);
  endfunction

  function automatic void advance_slave();
    if (polled_slave >= top_slave_id) polled_slave = 8'd0;
    else polled_slave = polled_slave + 8'd1;
  endfunction

  function automatic status_e parse_rx(logic [7:0] b);
    status_e st;
    st = ST_INCOMPL;
    case (parse_pos)
      RX_START: parse_pos = (b == CH_START) ? RX_ID : RX_START;
      RX_ID: begin
        frame_id  = b;
        parse_pos = RX_SEP1;
      end
      RX_SEP1: parse_pos = (b == CH_SEP) ? RX_DATA : RX_START;
      RX_DATA: begin
        frame_data = b;
        parse_pos  = RX_SEP2;
      end
      RX_SEP2: parse_pos = (b == CH_SEP) ? RX_CHK : RX_START;
      RX_CHK: parse_pos = ((frame_id ^ frame_data ^ b) == 8'd0) ? RX_END_OK : RX_END_BAD;
      RX_END_OK: begin
        if (b == CH_END) st = ST_OK;
        parse_pos = RX_START;
      end
      default: begin
        if (b == CH_END) st = ST_BADCHK;
        parse_pos = RX_START;
      end
    endcase
    return st;
  endfunction

  function automatic void compute_poll_step(kind_e k, logic [7:0] b);
    logic [7:0]  tgt;
    logic [7:0]  poll_frame [POLL_LEN];
    status_e     st;
    logic [7:0]  rid;
    logic [7:0]  rdat;
    logic [4:0]  next_retry;
    logic [16:0] next_silent;
    tgt  = polled_slave;
    rid  = 8'd0;
    rdat = 8'd0;
    if (!awaiting_reply && k == KIND_TX) begin
      poll_frame = '{CH_START, tgt, CH_SEP, tgt, CH_END};
      for (int i = 0; i < POLL_LEN; i++)
        push_result(1'b1, poll_frame[i], i == POLL_LEN - 1, 1'b1, ST_IGNORED, 8'd0, 8'd0, tgt);
      awaiting_reply = 1'b1;
      items_used++;
      return;
    end
    if (!awaiting_reply || (k != KIND_RX && k != KIND_POLL)) begin
      push_result(1'b0, 8'd0, 1'b1, 1'b0, ST_IGNORED, 8'd0, 8'd0, tgt);
      return;
    end
    items_used++;
    if (k == KIND_RX) st = parse_rx(b);
    else st = ST_INCOMPL;
    if (st == ST_OK) begin
      rid  = frame_id;
      rdat = frame_data;
      advance_slave();
      awaiting_reply = 1'b0;
    end else if (st == ST_BADCHK) begin
      rid        = frame_id;
      rdat       = frame_data;
      next_retry = {1'b0, retry_tally} + 5'd1;
      if (next_retry >= {1'b0, retry_max}) begin
        retry_tally = 4'd0;
        advance_slave();
      end else begin
        retry_tally = next_retry[3:0];
      end
      awaiting_reply = 1'b0;
    end else begin
      next_silent = {1'b0, silent_tally} + 17'd1;
      if (next_silent >= {1'b0, silent_max}) begin
        silent_tally = 16'd0;
        advance_slave();
        awaiting_reply = 1'b0;
      end else begin
        silent_tally = next_silent[15:0];
      end
    end
    push_result(1'b0, 8'd0, 1'b1, 1'b0, st, rid, rdat, tgt);
  endfunction

  task automatic send_item(kind_e k, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    compute_poll_step(k, b);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (poll_results_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LAST_ID: top_slave_id = val[7:0];
      CFG_RETRY:   retry_max    = val[3:0];
      CFG_NOFRAME: silent_max   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_reply(logic [7:0] id, logic [7:0] data, logic [7:0] chk,
                            int broken_at, bit mix_polls);
    logic [7:0] reply [7];
    reply = '{CH_START, id, CH_SEP, data, CH_SEP, chk, CH_END};
    if (broken_at >= 0) reply[broken_at] = 8'($urandom);
    foreach (reply[i]) begin
      if (mix_polls && $urandom_range(9) == 0) send_item(KIND_POLL, 8'($urandom));
      send_item(KIND_RX, reply[i]);
    end
  endtask

  // shapes: clean good reply, good with polls mixed in, damaged byte,
  // extra slot while a reply is due, bad checksum
  task automatic send_poll_exchange(int shape);
    logic [7:0] id;
    logic [7:0] data;
    logic [7:0] chk;
    id   = ($urandom_range(3) == 0) ? 8'($urandom) : polled_slave;
    data = 8'($urandom);
    chk  = id ^ data;
    if (shape >= 8) chk = chk ^ 8'($urandom_range(1, 255));
    if (!awaiting_reply) send_item(KIND_TX, 8'($urandom));
    if (shape == 7) send_item(KIND_TX, 8'($urandom));
    send_reply(id, data, chk, (shape == 6) ? int'($urandom_range(6)) : -1, shape == 4 || shape == 5);
  endtask

  task automatic test_directed();
    send_item(KIND_TX, 8'hFF);
    send_item(KIND_NONE, 8'h00);
    send_item(KIND_TX, 8'h5A);
    send_reply(8'h00, 8'hA5, 8'hA5, -1, 1'b0);
    send_item(KIND_POLL, 8'hFF);
    send_item(KIND_RX, CH_START);
    send_item(KIND_NONE, 8'hFF);
    send_item(KIND_TX, 8'h00);
    send_reply(8'hFF, 8'h0F, 8'h00, -1, 1'b0);
    send_item(KIND_TX, 8'hC3);
    send_item(KIND_RX, 8'h00);
    send_item(KIND_POLL, 8'h00);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_LAST_ID, 16'd0);
    write_reg(CFG_RETRY, 16'd1);
    write_reg(CFG_NOFRAME, 16'd1);
    repeat (3) begin
      send_item(KIND_TX, 8'($urandom));
      send_item(KIND_POLL, 8'($urandom));
    end
    send_poll_exchange(9);
    wait_drained();
    write_reg(CFG_LAST_ID, 16'h00FF);
    write_reg(CFG_RETRY, 16'd15);
    write_reg(CFG_NOFRAME, 16'hFFFF);
    repeat (3) send_poll_exchange(0);
    send_poll_exchange(8);
    send_item(KIND_TX, 8'($urandom));
    repeat (4) send_item(KIND_POLL, 8'($urandom));
    wait_drained();
    // limit now below the running count, slave id above the new last id
    write_reg(CFG_NOFRAME, 16'd2);
    write_reg(CFG_LAST_ID, 16'd1);
    send_item(KIND_POLL, 8'($urandom));
    send_poll_exchange(0);
    wait_drained();
  endtask

  task automatic run_random_phase(int send_pct, int recv_pct);
    int stop;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop = items_used + PHASE_ITEMS;
    while (items_used < stop) begin
      if ($urandom_range(99) < 75) send_poll_exchange($urandom_range(9));
      else send_item(kind_e'(2'($urandom_range(3))), 8'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    write_reg(CFG_LAST_ID, 16'd3);
    write_reg(CFG_RETRY, 16'd2);
    write_reg(CFG_NOFRAME, 16'd12);
    run_random_phase(26, 67);
    write_reg(CFG_LAST_ID, 16'($urandom_range(9)));
    write_reg(CFG_RETRY, 16'($urandom_range(1, 15)));
    write_reg(CFG_NOFRAME, 16'($urandom_range(1, 30)));
    run_random_phase(67, 26);
    write_reg(CFG_LAST_ID, 16'($urandom_range(255)));
    write_reg(CFG_RETRY, 16'($urandom_range(1, 4)));
    write_reg(CFG_NOFRAME, 16'($urandom_range(5, 60)));
    run_random_phase(0, 0);
  endtask

  task automatic test_output_stall();
    write_reg(CFG_LAST_ID, 16'd7);
    write_reg(CFG_RETRY, 16'd2);
    write_reg(CFG_NOFRAME, 16'd20);
    stall_req = 1'b1;
    repeat (4) send_poll_exchange($urandom_range(9));
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_LAST_ID;
    cfg_data_i    = 16'd0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_TX;
    rx_byte_i     = 8'd0;
    out_ready_i   = 1'b0;
    stall_req     = 1'b0;
    stall_left    = 0;
    send_idle_pct = 26;
    recv_idle_pct = 67;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_output_stall();
    $display("poll frames, replies good, bad and broken, idle polls and stray kinds: %0d items",
             items_sent);
    $display("%0d results checked across register extremes, idling mixes and an output stall",
             results_seen);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
